// ===== rtl/core/ribc_pkg.sv =====
// ----------------------------------------------------------------------------
// ribc_pkg
// Shared types, constants and helper functions for the cartridge image
// byte-order normalizer and boot-area checksum.
// ----------------------------------------------------------------------------
package ribc_pkg;

  // Layout codes as reported on the result channel.
  typedef enum logic [1:0] {
    LAYOUT_NATIVE   = 2'd0,
    LAYOUT_HALF     = 2'd1,
    LAYOUT_REVERSED = 2'd2,
    LAYOUT_INVALID  = 2'd3
  } layout_t;

  // Boot chip class codes.
  localparam logic [2:0] BOOT_UNKNOWN = 3'd0;
  localparam logic [2:0] BOOT_6101    = 3'd1;
  localparam logic [2:0] BOOT_6102    = 3'd2;
  localparam logic [2:0] BOOT_6103    = 3'd3;
  localparam logic [2:0] BOOT_6105    = 3'd4;
  localparam logic [2:0] BOOT_6106    = 3'd5;

  // Header marks of the first word, as read in file byte order.
  localparam logic [31:0] MARK_NATIVE   = 32'h8037_1240;
  localparam logic [31:0] MARK_HALF     = 32'h3780_4012;
  localparam logic [31:0] MARK_REVERSED = 32'h4012_3780;

  // Boot area window in words and accumulator width.
  localparam int unsigned CountW       = 11;
  localparam int unsigned SumW         = 42;
  localparam int unsigned NumKnown     = 6;
  localparam logic [CountW-1:0] SUM_FIRST_WORD = CountW'(32'h40 / 4);
  localparam logic [CountW-1:0] SUM_END_WORD   = CountW'(32'h1000 / 4);
  localparam logic [CountW-1:0] SUM_LAST_WORD  = CountW'(32'h1000 / 4 - 1);

  typedef logic [SumW-1:0]   sum_t;
  typedef logic [CountW-1:0] count_t;

  localparam sum_t KNOWN_SUMS [NumKnown] = '{
    42'h0D0027FDF31,
    42'h0CFFB631223,
    42'h0D057C85244,
    42'h0D6497E414B,
    42'h11A49F60E96,
    42'h0D6D5BE5580
  };
  localparam logic [2:0] KNOWN_CLASS [NumKnown] = '{
    BOOT_6101, BOOT_6101, BOOT_6102, BOOT_6103, BOOT_6105, BOOT_6106
  };

  // Picks the layout from the first word of an image.
  function automatic layout_t decode_layout(input logic [31:0] w);
    layout_t lay;
    case (w)
      MARK_NATIVE:   lay = LAYOUT_NATIVE;
      MARK_HALF:     lay = LAYOUT_HALF;
      MARK_REVERSED: lay = LAYOUT_REVERSED;
      default:       lay = LAYOUT_INVALID;
    endcase
    return lay;
  endfunction

  // Rearranges one word into big-endian order; invalid passes through.
  function automatic logic [31:0] normalize(input logic [31:0] w, input layout_t lay);
    logic [31:0] res;
    case (lay)
      LAYOUT_HALF:     res = {w[23:16], w[31:24], w[7:0], w[15:8]};
      LAYOUT_REVERSED: res = {w[7:0], w[15:8], w[23:16], w[31:24]};
      default:         res = w;
    endcase
    return res;
  endfunction

  // Matches the finished boot-area sum against the known values.
  function automatic logic [2:0] classify(input sum_t sum);
    logic [2:0] cls;
    cls = BOOT_UNKNOWN;
    for (int i = NumKnown - 1; i >= 0; i--) begin
      if (sum == KNOWN_SUMS[i]) begin
        cls = KNOWN_CLASS[i];
      end
    end
    return cls;
  endfunction

endpackage

// ===== rtl/core/rom_image_byte_order_and_boot_check.sv =====
// ----------------------------------------------------------------------------
// rom_image_byte_order_and_boot_check
// Normalizes cartridge image words to big-endian order and classifies the
// boot chip from the checksum of the boot area.
// ----------------------------------------------------------------------------
// Usage: feed the image one 32-bit word per request, first file byte in bits
// 31:24, with in_start_of_image on the header word. Every request yields one
// result through the input and result registers; the block takes a new
// request every cycle and holds up to two in flight, so it sustains one word
// per clock while the output is not stalled. The per-word step (byte swap,
// 42-bit add of the boot-area sum and the compare against six known sums on
// word 1023) sits in one register-to-register stage, and that stage sets the
// clock. Without a start marker after reset, words are counted from index 0
// in native layout.
module rom_image_byte_order_and_boot_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_raw_word,
  input  logic        in_start_of_image,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_normalized_word,
  output logic [1:0]  out_layout,
  output logic        out_boot_class_ready,
  output logic [2:0]  out_boot_class,
  output logic        out_image_too_short
);

  // Input register.
  logic        in_vld_r;
  logic [31:0] in_word_r;
  logic        in_start_r;
  logic        in_last_r;

  // Image state.
  ribc_pkg::layout_t layout_r, layout_nxt;
  ribc_pkg::count_t  word_count_r, word_count_nxt;
  ribc_pkg::sum_t    boot_sum_r, boot_sum_nxt;

  // Result register.
  logic              out_vld_r;
  logic [31:0]       out_word_r, out_word_nxt;
  ribc_pkg::layout_t out_layout_r;
  logic              out_ready_r, out_ready_nxt;
  logic [2:0]        out_class_r, out_class_nxt;
  logic              out_short_r, out_short_nxt;

  logic              out_free;
  logic              step;
  ribc_pkg::count_t  idx;
  ribc_pkg::sum_t    sum_base;

  // Handshake: the result slot frees when empty or taken this cycle.
  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r  <= in_raw_word;
      in_start_r <= in_start_of_image;
      in_last_r  <= in_last_word;
    end
  end

  // Per-word processing: layout, normalize, sum and classify.
  always_comb begin
    layout_nxt = in_start_r ? ribc_pkg::decode_layout(in_word_r) : layout_r;
    idx        = in_start_r ? '0 : word_count_r;
    sum_base   = in_start_r ? '0 : boot_sum_r;

    out_word_nxt = ribc_pkg::normalize(in_word_r, layout_nxt);

    if (idx >= ribc_pkg::SUM_FIRST_WORD && idx < ribc_pkg::SUM_END_WORD) begin
      boot_sum_nxt = sum_base + {{(ribc_pkg::SumW - 32){1'b0}}, out_word_nxt};
    end else begin
      boot_sum_nxt = sum_base;
    end

    out_ready_nxt = (idx == ribc_pkg::SUM_LAST_WORD);
    if (out_ready_nxt && layout_nxt != ribc_pkg::LAYOUT_INVALID) begin
      out_class_nxt = ribc_pkg::classify(boot_sum_nxt);
    end else begin
      out_class_nxt = ribc_pkg::BOOT_UNKNOWN;
    end

    out_short_nxt  = in_last_r && (idx < ribc_pkg::SUM_LAST_WORD);
    word_count_nxt = (idx < ribc_pkg::SUM_END_WORD) ? idx + 1'b1 : idx;
  end

  // State advances once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r     <= ribc_pkg::LAYOUT_NATIVE;
      word_count_r <= '0;
      boot_sum_r   <= '0;
    end else if (step) begin
      layout_r     <= layout_nxt;
      word_count_r <= word_count_nxt;
      boot_sum_r   <= boot_sum_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r   <= out_word_nxt;
      out_layout_r <= layout_nxt;
      out_ready_r  <= out_ready_nxt;
      out_class_r  <= out_class_nxt;
      out_short_r  <= out_short_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_normalized_word  = out_word_r;
  assign out_layout           = out_layout_r;
  assign out_boot_class_ready = out_ready_r;
  assign out_boot_class       = out_class_r;
  assign out_image_too_short  = out_short_r;

  // A class is only reported on the word that completes the sum.
  a_class_only_when_ready : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_class_r != ribc_pkg::BOOT_UNKNOWN) |-> out_ready_r)
    else $error("boot class reported outside the ready word");

  // A short image cannot also complete the boot area.
  a_short_excludes_ready : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_short_r && out_ready_r))
    else $error("short flag and boot class ready together");

  // The word counter saturates at the end of the boot area.
  a_count_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    word_count_r <= ribc_pkg::SUM_END_WORD)
    else $error("word counter beyond saturation");

  // A stall upstream only happens with a word waiting in the input register.
  a_stall_needs_word : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with nothing in flight");

  // Saturated counter never raises the ready flag again.
  a_no_ready_after_end : assert property (@(posedge clk) disable iff (!rst_n)
    step && !in_start_r && (word_count_r == ribc_pkg::SUM_END_WORD) |=> !out_ready_r)
    else $error("ready raised past the boot area");

endmodule
